FILE: rtl/core/assert_macros.svh
// assertion helpers, empty in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/qfc_pkg.sv
`timescale 1ns / 1ps
package qfc_pkg;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;
    localparam int IN_TDATA_W  = 272;
    localparam int OUT_TDATA_W = 64;
    localparam int ACC_W     = 72;
    localparam int NUM_STEPS = 33;
    localparam int STEP_W    = 6;

    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(1);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(NUM_STEPS);

    localparam logic signed [15:0] HOVER_Q8  = 16'sd1366;
    localparam logic signed [17:0] YAW_P_Q16 = 18'sd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALT_PI = 3'd0,
        REG_ALT_DV = 3'd1,
        REG_ATT_PD = 3'd2,
        REG_POS_PD = 3'd3,
        REG_POS_KI = 3'd4,
        REG_QUAT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                 start;
        logic [STEP_W-1:0]    step;
        logic                 commit;
    } t_dp_cmd;
endpackage

FILE: rtl/core/qfc_datapath.sv
`timescale 1ns / 1ps
module qfc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qfc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [qfc_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [qfc_pkg::IN_TDATA_W-1:0]      i_item,
    input  qfc_pkg::t_dp_cmd                    i_cmd,
    output logic [qfc_pkg::OUT_TDATA_W-1:0]     o_result
);
    import qfc_pkg::*;

    function automatic logic signed [15:0] f_sat16(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(32767)) return 16'sh7fff;
        if (v < -ACC_W'(32768)) return 16'sh8000;
        return v[15:0];
    endfunction
    function automatic logic signed [31:0] f_sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(64'sh7fffffff)) return 32'sh7fffffff;
        if (v < -ACC_W'(64'sh80000000)) return 32'sh80000000;
        return v[31:0];
    endfunction
    function automatic logic signed [15:0] f_lo(input logic [31:0] v);
        return v[15:0];
    endfunction
    function automatic logic signed [15:0] f_hi(input logic [31:0] v);
        return v[31:16];
    endfunction

    // configuration
    logic [CFG_W-1:0] r_cfg [NUM_REGS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_cfg[k] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ALT_PI: r_cfg[REG_ALT_PI] <= i_cfg_data;
                REG_ALT_DV: r_cfg[REG_ALT_DV] <= i_cfg_data;
                REG_ATT_PD: r_cfg[REG_ATT_PD] <= i_cfg_data;
                REG_POS_PD: r_cfg[REG_POS_PD] <= i_cfg_data;
                REG_POS_KI: r_cfg[REG_POS_KI] <= i_cfg_data;
                REG_QUAT:   r_cfg[REG_QUAT]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched item
    logic [IN_TDATA_W-1:0] r_in;
    logic signed [15:0] alt_tgt, alt_meas, vz, yaw_m, yaw_t, ex, ey, rr, pr;
    logic signed [15:0] qm [4];
    logic signed [15:0] qr [4];
    always_comb begin
        alt_tgt = r_in[15:0];  alt_meas = r_in[31:16];  vz = r_in[47:32];
        yaw_m = r_in[63:48];   yaw_t = r_in[79:64];
        ex = r_in[95:80];      ey = r_in[111:96];
        for (int k = 0; k < 4; k++) begin
            qm[k] = r_in[112 + 16*k +: 16];
            qr[k] = r_in[176 + 16*k +: 16];
        end
        rr = r_in[255:240];    pr = r_in[271:256];
    end

    // state
    logic signed [15:0] r_prev_alt_e, r_prev_yaw_e, r_prev_rt, r_prev_pt;
    logic signed [15:0] r_prev_ex, r_prev_ey;
    logic signed [31:0] r_alt_int, r_int_x, r_int_y;

    // working registers
    logic signed [15:0] r_tau0, r_tau1;
    logic signed [31:0] r_nix, r_niy;
    logic signed [ACC_W-1:0] r_acc, r_qw, r_q0, r_q1, r_alpha, r_beta, r_yacc, r_prod;
    logic signed [15:0] r_thr, r_yaw, r_roll, r_pitch;

    // saturated errors and new altitude integral of the held tick
    logic signed [15:0] w_e, w_yerr;
    logic signed [31:0] w_nint;
    always_comb begin
        w_e = f_sat16(ACC_W'(alt_tgt) - ACC_W'(alt_meas));
        w_yerr = f_sat16(ACC_W'(yaw_m) - ACC_W'(yaw_t));
        w_nint = f_sat32(ACC_W'(r_alt_int) + ACC_W'(w_e));
    end

    // one shared multiplier: operands per step, product registered
    logic signed [32:0] n_a, n_b;
    logic signed [65:0] w_prod;
    logic signed [17:0] ts;
    always_comb begin
        ts = {2'b00, r_cfg[REG_POS_KI][31:16]};
        n_a = '0; n_b = '0;
        case (i_cmd.step)
            6'd1:  begin n_a = 33'(f_lo(r_cfg[REG_ALT_PI])); n_b = 33'(w_e); end
            6'd2:  begin n_a = 33'(f_hi(r_cfg[REG_ALT_PI])); n_b = 33'(w_nint); end
            6'd3:  begin
                n_a = 33'(f_lo(r_cfg[REG_ALT_DV]));
                n_b = 33'(w_e) - 33'(r_prev_alt_e);
            end
            6'd4:  begin n_a = 33'(f_hi(r_cfg[REG_ALT_DV])); n_b = 33'(vz); end
            6'd5:  begin n_a = 33'(qr[0]); n_b = 33'(qm[0]); end
            6'd6:  begin n_a = 33'(qr[1]); n_b = 33'(qm[1]); end
            6'd7:  begin n_a = 33'(qr[2]); n_b = 33'(qm[2]); end
            6'd8:  begin n_a = 33'(qr[3]); n_b = 33'(qm[3]); end
            6'd9:  begin n_a = -33'(qr[0]); n_b = 33'(qm[1]); end
            6'd10: begin n_a = 33'(qr[1]); n_b = 33'(qm[0]); end
            6'd11: begin n_a = -33'(qr[2]); n_b = 33'(qm[3]); end
            6'd12: begin n_a = 33'(qr[3]); n_b = 33'(qm[2]); end
            6'd13: begin n_a = -33'(qr[0]); n_b = 33'(qm[2]); end
            6'd14: begin n_a = 33'(qr[1]); n_b = 33'(qm[3]); end
            6'd15: begin n_a = 33'(qr[2]); n_b = 33'(qm[0]); end
            6'd16: begin n_a = -33'(qr[3]); n_b = 33'(qm[1]); end
            6'd17: begin n_a = 33'(f_hi(r_cfg[REG_QUAT])); n_b = 33'(rr); end
            6'd18: begin n_a = 33'(f_hi(r_cfg[REG_QUAT])); n_b = 33'(pr); end
            6'd19: begin n_a = 33'(f_lo(r_cfg[REG_QUAT])); n_b = 33'(r_q0 >>> 14); end
            6'd20: begin n_a = 33'(f_lo(r_cfg[REG_QUAT])); n_b = 33'(r_q1 >>> 14); end
            6'd21: begin n_a = 33'(ex) + 33'(r_prev_ex); n_b = 33'(ts); end
            6'd22: begin n_a = 33'(ey) + 33'(r_prev_ey); n_b = 33'(ts); end
            6'd23: begin n_a = 33'(f_lo(r_cfg[REG_ATT_PD])); n_b = 33'(r_tau0); end
            6'd24: begin
                n_a = 33'(f_hi(r_cfg[REG_ATT_PD]));
                n_b = 33'(r_tau0) - 33'(r_prev_rt);
            end
            6'd25: begin n_a = 33'(f_lo(r_cfg[REG_ATT_PD])); n_b = 33'(r_tau1); end
            6'd26: begin
                n_a = 33'(f_hi(r_cfg[REG_ATT_PD]));
                n_b = 33'(r_tau1) - 33'(r_prev_pt);
            end
            6'd27: begin n_a = 33'(f_lo(r_cfg[REG_POS_PD])); n_b = 33'(ey); end
            6'd28: begin
                n_a = 33'(f_hi(r_cfg[REG_POS_PD]));
                n_b = 33'(ey) - 33'(r_prev_ey);
            end
            6'd29: begin n_a = 33'(f_lo(r_cfg[REG_POS_KI])); n_b = 33'(r_niy); end
            6'd30: begin n_a = 33'(f_lo(r_cfg[REG_POS_PD])); n_b = 33'(ex); end
            6'd31: begin
                n_a = 33'(f_hi(r_cfg[REG_POS_PD]));
                n_b = 33'(ex) - 33'(r_prev_ex);
            end
            6'd32: begin n_a = 33'(f_lo(r_cfg[REG_POS_KI])); n_b = 33'(r_nix); end
            6'd33: begin n_a = 33'(YAW_P_Q16); n_b = 33'(w_yerr); end
            default: ;
        endcase
    end
    assign w_prod = n_a * n_b;

    // accumulate stage works on product of previous step
    logic [STEP_W-1:0] r_pstep;
    logic r_pv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_pstep <= '0;
            r_prod <= '0;
            r_in <= '0;
            r_prev_alt_e <= '0; r_prev_yaw_e <= '0; r_prev_rt <= '0; r_prev_pt <= '0;
            r_prev_ex <= '0; r_prev_ey <= '0;
            r_alt_int <= '0; r_int_x <= '0; r_int_y <= '0;
            r_tau0 <= '0; r_tau1 <= '0; r_nix <= '0; r_niy <= '0;
            r_acc <= '0; r_qw <= '0; r_q0 <= '0; r_q1 <= '0;
            r_alpha <= '0; r_beta <= '0; r_yacc <= '0;
            r_thr <= '0; r_yaw <= '0; r_roll <= '0; r_pitch <= '0;
        end else begin
            r_pv <= (i_cmd.step != '0);
            r_pstep <= i_cmd.step;
            r_prod <= ACC_W'(w_prod);
            if (i_cmd.start) begin
                r_in <= i_item;
            end
            if (r_pv) begin
                case (r_pstep)
                    6'd1: r_acc <= ACC_W'(HOVER_Q8) * 256 + r_prod;
                    6'd2, 6'd3, 6'd4: r_acc <= r_acc + r_prod;
                    6'd5: r_qw <= r_prod;
                    6'd6, 6'd7, 6'd8: r_qw <= r_qw + r_prod;
                    6'd9: r_q0 <= r_prod;
                    6'd10, 6'd11, 6'd12: r_q0 <= r_q0 + r_prod;
                    6'd13: r_q1 <= r_prod;
                    6'd14, 6'd15: r_q1 <= r_q1 + r_prod;
                    6'd16: begin
                        // sign flip when the scalar part is negative
                        if (r_qw < 0) begin
                            r_q0 <= -r_q0;
                            r_q1 <= -(r_q1 + r_prod);
                        end else r_q1 <= r_q1 + r_prod;
                    end
                    6'd17: r_alpha <= -(r_prod * 16);
                    6'd18: r_beta <= -(r_prod * 16);
                    6'd19: r_tau0 <= f_sat16((r_alpha - r_prod) >>> 14);
                    6'd20: r_tau1 <= f_sat16((r_beta - r_prod) >>> 14);
                    6'd21: r_nix <= f_sat32(ACC_W'(r_int_x) + (r_prod >>> 9));
                    6'd22: r_niy <= f_sat32(ACC_W'(r_int_y) + (r_prod >>> 9));
                    6'd23: r_alpha <= r_prod;
                    6'd24: r_alpha <= (r_alpha + r_prod) * 256;
                    6'd25: r_beta <= r_prod;
                    6'd26: r_beta <= (r_beta + r_prod) * 256;
                    6'd27, 6'd28: r_alpha <= r_alpha + r_prod * 256;
                    6'd29: r_alpha <= r_alpha + r_prod;
                    6'd30, 6'd31: r_beta <= r_beta - r_prod * 256;
                    6'd32: r_beta <= r_beta - r_prod;
                    6'd33: r_yacc <= r_prod
                                   + (ACC_W'(w_yerr) - ACC_W'(r_prev_yaw_e)) * 131072;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_prev_alt_e <= w_e;   r_alt_int <= w_nint;
                r_prev_yaw_e <= w_yerr;
                r_prev_rt <= r_tau0;   r_prev_pt <= r_tau1;
                r_int_x <= r_nix;      r_int_y <= r_niy;
                r_prev_ex <= ex;       r_prev_ey <= ey;
                r_thr <= f_sat16(r_acc >>> 8);
                r_yaw <= f_sat16(r_yacc >>> 20);
                r_roll <= f_sat16(r_beta >>> 16);
                r_pitch <= f_sat16(r_alpha >>> 16);
            end
        end
    end

    assign o_result = {r_yaw, r_pitch, r_roll, r_thr};
endmodule

FILE: rtl/core/qfc_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qfc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output qfc_pkg::t_dp_cmd    o_cmd
);
    import qfc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_DONE} t_state;
    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic r_out_valid, n_out_valid;
    logic r_commit, n_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.start  = i_in_valid && o_in_ready;
    assign o_cmd.step   = (r_state == S_RUN) ? r_step : '0;
    assign o_cmd.commit = r_commit;

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        n_commit = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LOAD;
            S_LOAD: begin n_step = FIRST_STEP; n_state = S_RUN; end
            S_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                    n_step = '0;
                end else n_step = r_step + STEP_W'(1);
            end
            S_DONE: begin
                // let the last product drain and wait for a free result register
                if (r_commit) begin
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_out_valid) n_commit = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= '0;
            r_out_valid <= 1'b0;
            r_commit <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_out_valid <= n_out_valid;
            r_commit <= n_commit;
        end
    end

    `ASSERT_CLK(a_no_start_busy, i_clk, i_rst_n, (o_cmd.start |-> r_state == S_IDLE), "start while busy")
    `ASSERT_CLK(a_commit_done, i_clk, i_rst_n, (r_commit |-> r_state == S_DONE), "commit outside done")
    `ASSERT_CLK(a_valid_after, i_clk, i_rst_n, (r_commit |=> r_out_valid), "result not shown")
endmodule

FILE: rtl/core/quadrotor_flight_controller.sv
`timescale 1ns / 1ps
// quadrotor flight controller: one control tick per input beat, one beat of four
// saturated q7.8 commands out. a single shared 33x33 multiplier runs a fixed
// sequence of 33 products per tick before the result beat shows. the input
// is ready again once a tick is committed; a result that is still waiting only
// holds the commit of the following tick, not its accept. gains are written
// through the plain register port and must only change while no tick is in flight.
module quadrotor_flight_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qfc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [qfc_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // target_altitude, measured_altitude, vertical_velocity, yaw_measured,
    // desired yaw, position_error_x, position_error_y, measured_quaternion,
    // reference_quaternion, roll_rate, pitch_rate
    input  logic [qfc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // thrust_command, roll_command, pitch_command, yaw_command
    output logic [qfc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import qfc_pkg::*;
    t_dp_cmd w_cmd;

    qfc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(w_cmd)
    );
    qfc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_item(s_axis_tdata), .i_cmd(w_cmd), .o_result(m_axis_tdata)
    );
endmodule
